### design/skf_pkg.sv
// shared types and constants of the scalar kalman filter
`default_nettype none

package skf_pkg;

   // fixed widths of the external fields
   localparam int MEAS_W     = 32;
   localparam int EST_W      = 32;
   localparam int COV_W      = 31;
   localparam int GAIN_W     = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_INDEX_W = 3;

   // configuration register map
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STATE_GAIN_A  = 3'd0,
      CSR_MEAS_GAIN_H   = 3'd1,
      CSR_PROCESS_NOISE = 3'd2,
      CSR_MEAS_NOISE    = 3'd3,
      CSR_INIT_ESTIMATE = 3'd4,
      CSR_INIT_COV      = 3'd5
   } csr_index_type;

endpackage

`default_nettype wire

### design/scalar_kalman_filter.sv
// scalar kalman filter top level with shared multiplier and divider
//
// usage
//  - req channel: one measurement z per transaction (signed fixed point with
//    FRAC_BITS fraction bits); req_ready is high only while the filter is idle
//  - rsp channel: one transaction per measurement with the new estimate, the
//    new covariance, the gain and a flag for a zero gain divisor
//  - csr channel: register writes, taken only while the filter is idle; a write
//    of the initial estimate or covariance also loads the running state
//  - sequence: 9 multiplies on the single multiplier, each walking NCH slices
//    (NCH = ceil(DATA_WIDTH/16)), and one restoring division over the
//    DATA_WIDTH+FRAC_BITS numerator bits, plus accept and hand-off; the
//    division is skipped when the gain divisor is zero
//  - a new measurement is taken only once the previous step is through; the
//    single multiplier and the one-bit-per-cycle divider set the pace
//  - the result sits in an output register, so the next measurement is taken
//    while the previous result still waits; a stalled receiver only holds up
//    the hand-off at the end of the following step
//  - reset (synchronous, active high) restores A = H = R = P = 1.0, Q = 0 and
//    an estimate of 0, and drops any pending result
`default_nettype none

module scalar_kalman_filter #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // measurement transactions
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic signed [skf_pkg::MEAS_W-1:0]  req_measurement,
   // result transactions
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic signed [skf_pkg::EST_W-1:0]        rsp_estimate,
   output logic [skf_pkg::COV_W-1:0]               rsp_covariance,
   output logic signed [skf_pkg::GAIN_W-1:0]       rsp_gain,
   output logic                                    rsp_div_error,
   // register writes
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [skf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [skf_pkg::CSR_DATA_W-1:0]     csr_data
);

   import skf_pkg::*;

   // multiplier consumes 16 bits of the second operand per cycle
   localparam int CW  = 16;
   localparam int NCH = (DATA_WIDTH + CW - 1) / CW;
   localparam int MBW = NCH * CW;
   localparam int PW  = DATA_WIDTH + MBW;
   localparam int MCW = (NCH > 1) ? $clog2(NCH) : 1;
   localparam int QW  = PW - FRAC_BITS;
   // divider walks the DATA_WIDTH+FRAC_BITS bits of the shifted numerator
   localparam int NB  = DATA_WIDTH + FRAC_BITS;
   localparam int DCW = $clog2(NB);
   localparam int SW  = (QW > NB) ? QW : NB;
   localparam int WX  = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;

   localparam logic signed [DATA_WIDTH-1:0] SMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] SMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic [SW-1:0] LIM = SW'({1'b0, {(DATA_WIDTH-1){1'b1}}});
   localparam logic signed [DATA_WIDTH-1:0] ONE =
      (FRAC_BITS < DATA_WIDTH - 1) ? (DATA_WIDTH'(1) << FRAC_BITS) : SMAX;
   // added ahead of the shift to round a negative product toward minus infinity
   localparam logic [PW-1:0] RND = (PW'(1) << FRAC_BITS) - PW'(1);
   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOAD, ST_MUL, ST_SAT, ST_POST, ST_DLOAD, ST_DIV, ST_DSAT, ST_DONE
   } state_type;

   // multiply steps in program order; the division sits between hph and hxp
   typedef enum logic [3:0] {
      SP_XP, SP_AP, SP_APA, SP_PH, SP_HPH, SP_HXP, SP_KI, SP_KH, SP_KHP
   } step_type;

   // ---- helpers ----

   // 32-bit signed value into the working range
   function automatic logic signed [DATA_WIDTH-1:0] fit_s(input logic signed [31:0] v);
      logic signed [WX-1:0] e;
      e = WX'(v);
      if (e > WX'(SMAX)) return SMAX;
      if (e < WX'(SMIN)) return SMIN;
      return DATA_WIDTH'(e);
   endfunction

   function automatic logic [DATA_WIDTH-1:0] mag_of(input logic signed [DATA_WIDTH-1:0] v);
      return v[DATA_WIDTH-1] ? DATA_WIDTH'(-v) : DATA_WIDTH'(v);
   endfunction

   function automatic logic signed [DATA_WIDTH-1:0] sat_sum(
      input logic signed [DATA_WIDTH-1:0] a,
      input logic signed [DATA_WIDTH-1:0] b,
      input logic                         sub
   );
      logic signed [DATA_WIDTH:0] s;
      s = sub ? ((DATA_WIDTH+1)'(a) - (DATA_WIDTH+1)'(b))
              : ((DATA_WIDTH+1)'(a) + (DATA_WIDTH+1)'(b));
      if (s > (DATA_WIDTH+1)'(SMAX)) return SMAX;
      if (s < (DATA_WIDTH+1)'(SMIN)) return SMIN;
      return DATA_WIDTH'(s);
   endfunction

   // working value onto the 32-bit signed output range
   function automatic logic signed [31:0] to_s32(input logic signed [DATA_WIDTH-1:0] v);
      logic signed [WX-1:0] e;
      e = WX'(v);
      if (e > WX'(S32_MAX)) return S32_MAX;
      if (e < WX'(S32_MIN)) return S32_MIN;
      return e[31:0];
   endfunction

   // non-negative working value onto the 31-bit covariance range
   function automatic logic [COV_W-1:0] to_u31(input logic signed [DATA_WIDTH-1:0] v);
      logic signed [WX-1:0] e;
      e = WX'(v);
      if (e > WX'(S32_MAX)) return {COV_W{1'b1}};
      return e[COV_W-1:0];
   endfunction

   // ---- registers ----

   state_type state_ff;
   step_type  step_ff;

   // configuration and filter state
   logic signed [DATA_WIDTH-1:0] a_ff, h_ff, q_ff, r_ff;
   logic signed [DATA_WIDTH-1:0] est_ff, cov_ff;

   // per-step working values
   logic signed [DATA_WIDTH-1:0] z_ff, xp_ff, pp_ff, num_ff, den_ff, k_ff, tmp_ff, prod_ff;
   logic                         err_ff;

   // shared multiplier
   logic [DATA_WIDTH-1:0] ma_ff;
   logic [MBW-1:0]        mb_ff;
   logic                  mneg_ff;
   logic [PW-1:0]         acc_ff;
   logic [MCW-1:0]        mcnt_ff;

   // restoring divider: numerator bits shift out at the top, quotient bits in
   logic [NB-1:0]         dq_ff;
   logic [DATA_WIDTH-1:0] drem_ff, dm_ff;
   logic                  dneg_ff;
   logic [DCW-1:0]        dcnt_ff;

   // output register
   logic                     rsp_valid_ff;
   logic signed [EST_W-1:0]  rsp_estimate_ff;
   logic [COV_W-1:0]         rsp_covariance_ff;
   logic signed [GAIN_W-1:0] rsp_gain_ff;
   logic                     rsp_div_error_ff;

   // ---- combinational ----

   logic signed [DATA_WIDTH-1:0] op_a, op_b;
   logic [CW-1:0]                mchunk;
   logic [DATA_WIDTH+CW-1:0]     mpart;
   logic [PW-1:0]                acc_in;
   logic [DATA_WIDTH:0]          drs;
   logic                         dge;
   logic [DATA_WIDTH-1:0]        drem_in;
   logic                         sat_neg;
   logic [SW-1:0]                sat_mag;
   logic signed [DATA_WIDTH-1:0] sat_val;
   logic signed [DATA_WIDTH-1:0] pnew;

   // operand pair of each multiply step
   always_comb begin
      case (step_ff)
         SP_XP:   begin op_a = a_ff;   op_b = est_ff; end
         SP_AP:   begin op_a = a_ff;   op_b = cov_ff; end
         SP_APA:  begin op_a = tmp_ff; op_b = a_ff;   end
         SP_PH:   begin op_a = pp_ff;  op_b = h_ff;   end
         SP_HPH:  begin op_a = num_ff; op_b = h_ff;   end
         SP_HXP:  begin op_a = h_ff;   op_b = xp_ff;  end
         SP_KI:   begin op_a = k_ff;   op_b = tmp_ff; end
         SP_KH:   begin op_a = k_ff;   op_b = h_ff;   end
         SP_KHP:  begin op_a = tmp_ff; op_b = pp_ff;  end
         default: begin op_a = a_ff;   op_b = est_ff; end
      endcase
   end

   // one 16-bit slice per cycle, top slice first, rounding bias on the last
   assign mchunk = mb_ff[MBW-1 -: CW];
   assign mpart  = ma_ff * mchunk;
   assign acc_in = (acc_ff << CW) + PW'(mpart)
                 + (((mcnt_ff == '0) && mneg_ff) ? RND : '0);

   assign drs     = {drem_ff, dq_ff[NB-1]};
   assign dge     = drs >= {1'b0, dm_ff};
   assign drem_in = dge ? DATA_WIDTH'(drs - {1'b0, dm_ff}) : drs[DATA_WIDTH-1:0];

   // shared sign and saturation stage for product and quotient
   always_comb begin
      if (state_ff == ST_DSAT) begin
         sat_neg = dneg_ff;
         sat_mag = SW'(dq_ff);
      end else begin
         sat_neg = mneg_ff;
         sat_mag = SW'(acc_ff[PW-1:FRAC_BITS]);
      end
      if (sat_mag > LIM) begin
         sat_val = sat_neg ? SMIN : SMAX;
      end else if (sat_neg) begin
         sat_val = -DATA_WIDTH'(sat_mag);
      end else begin
         sat_val = DATA_WIDTH'(sat_mag);
      end
   end

   assign pnew = sat_sum(pp_ff, prod_ff, 1'b1);

   // ---- sequencer ----

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= SP_XP;
         rsp_valid_ff <= 1'b0;
         err_ff       <= 1'b0;
         a_ff         <= ONE;
         h_ff         <= ONE;
         q_ff         <= '0;
         r_ff         <= ONE;
         est_ff       <= '0;
         cov_ff       <= ONE;
      end else begin
         // taken result leaves unless the hand-off below replaces it
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_STATE_GAIN_A:  a_ff   <= fit_s(csr_data);
               CSR_MEAS_GAIN_H:   h_ff   <= fit_s(csr_data);
               CSR_PROCESS_NOISE: q_ff   <= fit_s({1'b0, csr_data[30:0]});
               CSR_MEAS_NOISE:    r_ff   <= fit_s({1'b0, csr_data[30:0]});
               CSR_INIT_ESTIMATE: est_ff <= fit_s(csr_data);
               CSR_INIT_COV:      cov_ff <= fit_s({1'b0, csr_data[30:0]});
               default: ;
            endcase
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  z_ff     <= fit_s(req_measurement);
                  err_ff   <= 1'b0;
                  step_ff  <= SP_XP;
                  state_ff <= ST_LOAD;
               end
            end

            ST_LOAD: begin
               ma_ff    <= mag_of(op_a);
               mb_ff    <= MBW'(mag_of(op_b));
               mneg_ff  <= op_a[DATA_WIDTH-1] ^ op_b[DATA_WIDTH-1];
               acc_ff   <= '0;
               mcnt_ff  <= MCW'(NCH - 1);
               state_ff <= ST_MUL;
            end

            ST_MUL: begin
               acc_ff  <= acc_in;
               mb_ff   <= mb_ff << CW;
               mcnt_ff <= mcnt_ff - MCW'(1);
               if (mcnt_ff == '0) begin
                  state_ff <= ST_SAT;
               end
            end

            ST_SAT: begin
               prod_ff  <= sat_val;
               state_ff <= ST_POST;
            end

            ST_POST: begin
               case (step_ff)
                  SP_XP: begin
                     xp_ff    <= prod_ff;
                     step_ff  <= SP_AP;
                     state_ff <= ST_LOAD;
                  end
                  SP_AP: begin
                     tmp_ff   <= prod_ff;
                     step_ff  <= SP_APA;
                     state_ff <= ST_LOAD;
                  end
                  SP_APA: begin
                     pp_ff    <= sat_sum(prod_ff, q_ff, 1'b0);
                     step_ff  <= SP_PH;
                     state_ff <= ST_LOAD;
                  end
                  SP_PH: begin
                     num_ff   <= prod_ff;
                     step_ff  <= SP_HPH;
                     state_ff <= ST_LOAD;
                  end
                  SP_HPH: begin
                     den_ff   <= sat_sum(prod_ff, r_ff, 1'b0);
                     state_ff <= ST_DLOAD;
                  end
                  SP_HXP: begin
                     // innovation z - H*xp
                     tmp_ff   <= sat_sum(z_ff, prod_ff, 1'b1);
                     step_ff  <= SP_KI;
                     state_ff <= ST_LOAD;
                  end
                  SP_KI: begin
                     est_ff   <= sat_sum(xp_ff, prod_ff, 1'b0);
                     step_ff  <= SP_KH;
                     state_ff <= ST_LOAD;
                  end
                  SP_KH: begin
                     tmp_ff   <= prod_ff;
                     step_ff  <= SP_KHP;
                     state_ff <= ST_LOAD;
                  end
                  SP_KHP: begin
                     // covariance never goes below zero
                     cov_ff   <= pnew[DATA_WIDTH-1] ? '0 : pnew;
                     state_ff <= ST_DONE;
                  end
                  default: state_ff <= ST_IDLE;
               endcase
            end

            ST_DLOAD: begin
               if (den_ff == '0) begin
                  // zero divisor: gain 0 and flag, update goes on
                  err_ff   <= 1'b1;
                  k_ff     <= '0;
                  step_ff  <= SP_HXP;
                  state_ff <= ST_LOAD;
               end else begin
                  dq_ff    <= {mag_of(num_ff), {FRAC_BITS{1'b0}}};
                  drem_ff  <= '0;
                  dm_ff    <= mag_of(den_ff);
                  dneg_ff  <= num_ff[DATA_WIDTH-1] ^ den_ff[DATA_WIDTH-1];
                  dcnt_ff  <= DCW'(NB - 1);
                  state_ff <= ST_DIV;
               end
            end

            ST_DIV: begin
               drem_ff <= drem_in;
               dq_ff   <= {dq_ff[NB-2:0], dge};
               dcnt_ff <= dcnt_ff - DCW'(1);
               if (dcnt_ff == '0) begin
                  state_ff <= ST_DSAT;
               end
            end

            ST_DSAT: begin
               k_ff     <= sat_val;
               step_ff  <= SP_HXP;
               state_ff <= ST_LOAD;
            end

            ST_DONE: begin
               // hand off once the output register is free
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_estimate_ff   <= to_s32(est_ff);
                  rsp_covariance_ff <= to_u31(cov_ff);
                  rsp_gain_ff       <= to_s32(k_ff);
                  rsp_div_error_ff  <= err_ff;
                  state_ff          <= ST_IDLE;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // ---- ports ----

   assign req_ready      = (state_ff == ST_IDLE);
   assign csr_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_estimate   = rsp_estimate_ff;
   assign rsp_covariance = rsp_covariance_ff;
   assign rsp_gain       = rsp_gain_ff;
   assign rsp_div_error  = rsp_div_error_ff;

endmodule

`default_nettype wire

### design/skf_checker.sv
// port-level assertions for the scalar kalman filter, bound to the top level
`default_nettype none

module skf_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_ready,
   input wire logic                              csr_ready,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic signed [skf_pkg::EST_W-1:0]  rsp_estimate,
   input wire logic [skf_pkg::COV_W-1:0]         rsp_covariance,
   input wire logic signed [skf_pkg::GAIN_W-1:0] rsp_gain,
   input wire logic                              rsp_div_error
);

   import skf_pkg::*;

   // ready is low in the cycle after an accepted measurement
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("filter ready right after accepting a measurement");

   // register writes and measurements are taken in the same idle window
   a_csr_matches_req: assert property (@(posedge clock) disable iff (reset)
      csr_ready == req_ready)
      else $error("csr and req ready disagree");

   // a zero divisor always reports a zero gain
   a_div_error_gain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_div_error |-> rsp_gain == '0)
      else $error("divide error with nonzero gain");

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_estimate)
         && $stable(rsp_covariance) && $stable(rsp_gain))
      else $error("result changed while stalled");

endmodule

bind scalar_kalman_filter skf_checker u_skf_checker (.*);

`default_nettype wire

### tb/tb_top.sv
// self-checking testbench for the scalar kalman filter: fixed-point predictor, stimulus, checks
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import skf_pkg::*;

   // fixed-point format of the default build
   localparam int FRAC = 16;
   localparam longint FX_ONE = 64'sd65536;
   localparam longint SAT_HI = 64'sd2147483647;
   localparam longint SAT_LO = -64'sd2147483648;

   localparam logic signed [MEAS_W-1:0] MEAS_ONE = 32'sd65536;
   localparam logic signed [MEAS_W-1:0] MEAS_MAX = 32'sh7fffffff;
   localparam logic signed [MEAS_W-1:0] MEAS_MIN = 32'sh80000000;

   // indexes past the register map, writes there must leave everything alone
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   // the watchdog limit lies well beyond one step plus the longest receiver stall
   // and sender pause, so that many quiet cycles means a hang
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 200;

   typedef struct packed {
      logic signed [EST_W-1:0]  estimate;
      logic [COV_W-1:0]         covariance;
      logic signed [GAIN_W-1:0] gain;
      logic                     div_error;
   } kalman_result_type;

   typedef enum int {RX_READY, RX_COIN, RX_LONG_STALL} rx_mode_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic signed [MEAS_W-1:0]      req_measurement;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic signed [EST_W-1:0]       rsp_estimate;
   logic [COV_W-1:0]              rsp_covariance;
   logic signed [GAIN_W-1:0]      rsp_gain;
   logic                          rsp_div_error;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [CSR_INDEX_W-1:0]        csr_index;
   logic [CSR_DATA_W-1:0]         csr_data;

   // predictor copy of the registers and the running filter state
   logic signed [CSR_DATA_W-1:0]  coef_a;
   logic signed [CSR_DATA_W-1:0]  coef_h;
   logic [COV_W-1:0]              noise_q;
   logic [COV_W-1:0]              noise_r;
   logic signed [EST_W-1:0]       est_state;
   logic [COV_W-1:0]              cov_state;

   // predicted results, oldest first
   kalman_result_type pending_results[$];

   int error_count = 0;
   int items_sent = 0;
   int results_checked = 0;
   int div_errors_seen = 0;
   int reg_writes = 0;
   int idle_cycles = 0;

   // sender burst control
   int burst_left = 0;
   bit sender_gaps = 1'b1;

   // receiver stall pattern
   rx_mode_type rx_mode = RX_READY;
   int rx_mode_left = 0;
   int rx_hold = 0;

   scalar_kalman_filter dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_measurement (req_measurement),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_estimate    (rsp_estimate),
      .rsp_covariance  (rsp_covariance),
      .rsp_gain        (rsp_gain),
      .rsp_div_error   (rsp_div_error),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // fixed-point arithmetic of the filter
   // ---------------------------------------------------------------------

   // clamp to the signed 32-bit working range
   function automatic longint fx_sat(input longint v);
      if (v > SAT_HI) return SAT_HI;
      if (v < SAT_LO) return SAT_LO;
      return v;
   endfunction

   // exact product, floor shift by the fraction bits, then clamp
   function automatic longint fx_mul(input longint a, input longint b);
      return fx_sat((a * b) >>> FRAC);
   endfunction

   function automatic longint fx_add(input longint a, input longint b);
      return fx_sat(a + b);
   endfunction

   function automatic longint fx_sub(input longint a, input longint b);
      return fx_sat(a - b);
   endfunction

   // (n << FRAC) / d truncated toward zero; zero divisor gives 0 and a flag
   function automatic longint fx_div(input longint n, input longint d, output bit zero_den);
      zero_den = (d == 0);
      if (zero_den) return 0;
      return fx_sat((n * FX_ONE) / d);
   endfunction

   function automatic void reset_predictor();
      coef_a    = 32'sd65536;
      coef_h    = 32'sd65536;
      noise_q   = '0;
      noise_r   = 31'd65536;
      est_state = '0;
      cov_state = 31'd65536;
   endfunction

   // register write as the block sees it; the estimate and covariance
   // registers also load the running state
   function automatic void apply_reg_write(input logic [CSR_INDEX_W-1:0] idx,
                                           input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_STATE_GAIN_A:  coef_a = data;
         CSR_MEAS_GAIN_H:   coef_h = data;
         CSR_PROCESS_NOISE: noise_q = data[COV_W-1:0];
         CSR_MEAS_NOISE:    noise_r = data[COV_W-1:0];
         CSR_INIT_ESTIMATE: est_state = data;
         CSR_INIT_COV:      cov_state = data[COV_W-1:0];
         default: ;
      endcase
   endfunction

   // one predict/update step of the filter, advancing the running state
   function automatic kalman_result_type predict_step(input logic signed [MEAS_W-1:0] z);
      longint xp, pp, num, den, k, innov, x_new, p_new;
      bit zero_den;
      kalman_result_type res;
      xp    = fx_mul(coef_a, est_state);
      pp    = fx_add(fx_mul(fx_mul(coef_a, cov_state), coef_a), noise_q);
      num   = fx_mul(pp, coef_h);
      den   = fx_add(fx_mul(fx_mul(coef_h, pp), coef_h), noise_r);
      k     = fx_div(num, den, zero_den);
      innov = fx_sub(z, fx_mul(coef_h, xp));
      x_new = fx_add(xp, fx_mul(k, innov));
      p_new = fx_sub(pp, fx_mul(fx_mul(k, coef_h), pp));
      // rounding and saturation can push the covariance below zero
      if (p_new < 0) p_new = 0;
      est_state = x_new[EST_W-1:0];
      cov_state = p_new[COV_W-1:0];
      res.estimate   = x_new[EST_W-1:0];
      res.covariance = p_new[COV_W-1:0];
      res.gain       = k[GAIN_W-1:0];
      res.div_error  = zero_den;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // result checking
   // ---------------------------------------------------------------------

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         error_count++;
         $display("[%0t] %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // every result transaction is compared with the oldest prediction
   always @(posedge clock) begin : check_results
      kalman_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            error_count++;
            $display("[%0t] result with no measurement pending, estimate %0d",
                     $time, rsp_estimate);
         end else begin
            want = pending_results[0];
            pending_results.delete(0);
            check_field("estimate", $signed(want.estimate), rsp_estimate);
            check_field("covariance", want.covariance, rsp_covariance);
            check_field("gain", $signed(want.gain), rsp_gain);
            check_field("div_error", want.div_error, rsp_div_error);
            results_checked++;
            if (rsp_div_error) div_errors_seen++;
         end
      end
   end

   // receiver: switches between always ready, coin flips and long stalls
   always @(posedge clock) begin
      if (rx_mode_left == 0) begin
         rx_mode      <= rx_mode_type'($urandom_range(0, 2));
         rx_mode_left <= $urandom_range(40, 600);
      end else begin
         rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
         RX_READY: rsp_ready <= 1'b1;
         RX_COIN:  rsp_ready <= ($urandom_range(0, 1) == 1);
         RX_LONG_STALL: begin
            if (rx_hold == 0) begin
               rsp_ready <= !rsp_ready;
               // going low holds long, going high only briefly
               rx_hold   <= rsp_ready ? $urandom_range(1, 150) : $urandom_range(0, 6);
            end else begin
               rx_hold <= rx_hold - 1;
            end
         end
         default: rsp_ready <= 1'b1;
      endcase
   end

   // watchdog: too long without any transaction ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[%0t] no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------

   // one measurement transaction; valid stays up for a following item in the
   // same burst, and drops only for a gap
   task automatic send_measurement(input logic signed [MEAS_W-1:0] z);
      int gap;
      if (csr_valid) csr_valid <= 1'b0;
      req_valid       <= 1'b1;
      req_measurement <= z;
      do @(posedge clock); while (!req_ready);
      pending_results.insert(pending_results.size(), predict_step(z));
      items_sent++;
      if (sender_gaps) begin
         if (burst_left == 0) begin
            // mostly short gaps, some long enough to span a whole step
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 140) : $urandom_range(1, 12);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
            burst_left = $urandom_range(1, 16);
         end else begin
            burst_left--;
         end
      end
   endtask

   // hold the sender until every predicted result has been checked
   task automatic wait_for_results();
      if (req_valid) req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // one register write transaction; valid is dropped by the next sender
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      apply_reg_write(idx, data);
      reg_writes++;
   endtask

   // full register set, written once the filter has gone idle
   task automatic load_config(input logic [CSR_DATA_W-1:0] a, input logic [CSR_DATA_W-1:0] h,
                              input logic [CSR_DATA_W-1:0] q, input logic [CSR_DATA_W-1:0] r,
                              input logic [CSR_DATA_W-1:0] x0,
                              input logic [CSR_DATA_W-1:0] p0);
      wait_for_results();
      write_reg(CSR_STATE_GAIN_A, a);
      write_reg(CSR_MEAS_GAIN_H, h);
      write_reg(CSR_PROCESS_NOISE, q);
      write_reg(CSR_MEAS_NOISE, r);
      write_reg(CSR_INIT_ESTIMATE, x0);
      write_reg(CSR_INIT_COV, p0);
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // reset values: A = H = R = P = 1.0, Q = 0, estimate 0
   task automatic test_reset_defaults();
      send_measurement(32'sd0);
      send_measurement(MEAS_ONE);
      send_measurement(-MEAS_ONE);
      send_measurement(MEAS_MAX);
      send_measurement(MEAS_MIN);
      send_measurement(32'sd1);
   endtask

   // writes past the register map change nothing
   task automatic test_unknown_index();
      wait_for_results();
      write_reg(CSR_SPARE_LO, 32'hffffffff);
      write_reg(CSR_SPARE_HI, 32'h80000001);
      send_measurement(32'sd131072);
   endtask

   // initial estimate and covariance reload the running state; the top data
   // bit of the covariance write is dropped
   task automatic test_initial_load();
      wait_for_results();
      write_reg(CSR_INIT_ESTIMATE, MEAS_MIN);
      write_reg(CSR_INIT_COV, 32'hffffffff);
      send_measurement(MEAS_MAX);
      send_measurement(MEAS_MIN);
      wait_for_results();
      write_reg(CSR_INIT_ESTIMATE, MEAS_MAX);
      write_reg(CSR_INIT_COV, 32'h0);
      send_measurement(-MEAS_ONE);
   endtask

   // zero gain divisor, once from H = R = 0 and once from a zero covariance
   task automatic test_zero_divisor();
      wait_for_results();
      write_reg(CSR_MEAS_GAIN_H, 32'h0);
      write_reg(CSR_MEAS_NOISE, 32'h0);
      send_measurement(MEAS_ONE);
      send_measurement(MEAS_MIN);
      wait_for_results();
      write_reg(CSR_MEAS_GAIN_H, MEAS_ONE);
      write_reg(CSR_PROCESS_NOISE, 32'h0);
      write_reg(CSR_INIT_COV, 32'h0);
      send_measurement(32'sd12345);
   endtask

   // saturated products drive the covariance negative, where it clamps to
   // zero; then every register at an extreme
   task automatic test_covariance_clamp();
      load_config(MEAS_ONE, 32'sd262144, 32'h0, 32'h0, 32'h0, 32'h40000000);
      send_measurement(MEAS_ONE);
      load_config(MEAS_MAX, MEAS_MIN, 32'hffffffff, 32'h7fffffff, MEAS_MIN, 32'h7fffffff);
      send_measurement(MEAS_MAX);
      send_measurement(MEAS_MIN);
      send_measurement(32'sd0);
      wait_for_results();
      write_reg(CSR_STATE_GAIN_A, MEAS_MIN);
      send_measurement(-32'sd1);
   endtask

   // noisy measurements of a drifting value around the loaded estimate, with
   // occasional outliers anywhere in the field range
   task automatic run_tracking_phase(input int count, input int spread);
      longint truth;
      logic signed [MEAS_W-1:0] z;
      truth = est_state;
      for (int i = 0; i < count; i++) begin
         truth = fx_sat(truth + longint'($urandom_range(0, 2 * 6554)) - 6554);
         if ($urandom_range(0, 15) == 0)
            z = $urandom();
         else
            z = MEAS_W'(fx_sat(truth + longint'($urandom_range(0, 2 * spread)) - spread));
         send_measurement(z);
         // sender pause mid-stream until the filter has drained
         if (i == count / 2 || $urandom_range(0, 63) == 0)
            wait_for_results();
      end
   endtask

   // realistic filter settings, each phase with new coefficients
   task automatic test_tracking();
      logic signed [CSR_DATA_W-1:0] a, h, x0;
      logic [CSR_DATA_W-1:0] q, r, p0;
      for (int phase = 0; phase < 8; phase++) begin
         a = $urandom_range(58982, 72090);
         if ($urandom_range(0, 3) == 0)
            a = -a;
         else if ($urandom_range(0, 3) == 0)
            a = $urandom_range(0, 98304);
         h = $urandom_range(16384, 196608);
         if ($urandom_range(0, 3) == 0) h = -h;
         q  = ($urandom_range(0, 3) == 0) ? 32'h0 : 32'($urandom_range(0, 6554));
         r  = $urandom_range(655, 655360);
         x0 = $urandom_range(0, 13107200) - 6553600;
         p0 = $urandom_range(0, 6553600);
         // one phase runs the sender back to back
         sender_gaps = (phase != 2);
         load_config(a, h, q, r, x0, p0);
         run_tracking_phase(110, $urandom_range(0, 327680));
      end
      sender_gaps = 1'b1;
   endtask

   // registers and measurements drawn over their whole range
   task automatic test_full_range();
      for (int phase = 0; phase < 3; phase++) begin
         load_config($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
         for (int i = 0; i < 90; i++) begin
            case ($urandom_range(0, 9))
               0: send_measurement(MEAS_MAX);
               1: send_measurement(MEAS_MIN);
               default: send_measurement($urandom());
            endcase
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_measurement = '0;
      csr_valid       = 1'b0;
      csr_index       = CSR_STATE_GAIN_A;
      csr_data        = '0;
      reset_predictor();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_unknown_index();
      test_initial_load();
      test_zero_divisor();
      test_covariance_clamp();
      test_tracking();
      test_full_range();

      // drain, then leave room for a stray late result
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d measurements and %0d register writes over directed, tracking",
               items_sent, reg_writes);
      $display("and full-range settings; %0d results checked, %0d with a zero divisor",
               results_checked, div_errors_seen);
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
